FILE: hdl/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types and constants for the motor command frame encoder.
// ----------------------------------------------------------------------------
package mcfe_pkg;

    // Lanes of the quantiser, one per setpoint
    localparam int NLANE     = 5;
    localparam int LANE_POS  = 0;
    localparam int LANE_VEL  = 1;
    localparam int LANE_TOR  = 2;
    localparam int LANE_KP   = 3;
    localparam int LANE_KD   = 4;

    localparam int VAL_W     = 32;            // Q16.16 setpoint width
    localparam int CODE_W    = 16;            // widest code (position)
    localparam int NUM_W     = VAL_W + CODE_W;
    localparam int DIV_STEPS = CODE_W;        // one quotient bit per stage
    localparam int FRAME_LEN = 11;
    localparam int NREG      = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [7:0] HEADER_BYTE = 8'd123;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_POS_MIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POS_MAX   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VEL_MIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VEL_MAX   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TOR_MIN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TOR_MAX   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STIFF_MAX = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_MAX  = 3'd7;

    // Register reset values
    localparam logic [31:0] RST_POS_MIN   = 32'hFFF3_8000;
    localparam logic [31:0] RST_POS_MAX   = 32'h000C_8000;
    localparam logic [31:0] RST_VEL_MIN   = 32'hFFE2_0000;
    localparam logic [31:0] RST_VEL_MAX   = 32'h001E_0000;
    localparam logic [31:0] RST_TOR_MIN   = 32'hFFF6_0000;
    localparam logic [31:0] RST_TOR_MAX   = 32'h000A_0000;
    localparam logic [31:0] RST_STIFF_MAX = 32'h01F4_0000;
    localparam logic [31:0] RST_DAMP_MAX  = 32'h0005_0000;

    typedef struct packed {
        logic [7:0]         motor_number;
        logic signed [31:0] target_position;
        logic signed [31:0] target_velocity;
        logic signed [31:0] target_torque;
        logic signed [31:0] stiffness_gain;
        logic signed [31:0] damping_gain;
    } t_cmd;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_out;

endpackage

FILE: hdl/mcfe_prep.sv
// ----------------------------------------------------------------------------
// mcfe_prep
// Clamp each setpoint to its range, form the span and scale by 2^bits - 1.
// Two register stages.
// ----------------------------------------------------------------------------
module mcfe_prep
    import mcfe_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [7:0]                         i_motor,
    input  logic [NLANE-1:0][VAL_W-1:0]        i_x,
    input  logic [NLANE-1:0][VAL_W-1:0]        i_lo,
    input  logic [NLANE-1:0][VAL_W-1:0]        i_hi,
    output logic                               o_valid,
    output logic [7:0]                         o_motor,
    output logic [NLANE-1:0][NUM_W-1:0]        o_num,
    output logic [NLANE-1:0][VAL_W-1:0]        o_span,
    output logic [NLANE-1:0]                   o_zero
);

    logic                         r1_valid;
    logic [7:0]                   r1_motor;
    logic [NLANE-1:0][VAL_W-1:0]  r1_d;
    logic [NLANE-1:0][VAL_W-1:0]  r1_span;
    logic [NLANE-1:0]             r1_zero;
    logic [NLANE-1:0][VAL_W-1:0]  n1_d;
    logic [NLANE-1:0][VAL_W-1:0]  n1_span;
    logic [NLANE-1:0]             n1_zero;

    logic                         r2_valid;
    logic [7:0]                   r2_motor;
    logic [NLANE-1:0][NUM_W-1:0]  r2_num;
    logic [NLANE-1:0][VAL_W-1:0]  r2_span;
    logic [NLANE-1:0]             r2_zero;
    logic [NLANE-1:0][NUM_W-1:0]  n2_num;

    // Stage 1: clamp, offset and span
    always_comb begin
        logic signed [VAL_W:0] x, lo, hi, xc, d, s;
        for (int l = 0; l < NLANE; l++) begin
            x  = {i_x[l][VAL_W-1], i_x[l]};
            lo = {i_lo[l][VAL_W-1], i_lo[l]};
            hi = {i_hi[l][VAL_W-1], i_hi[l]};
            if (x > hi) begin
                xc = hi;
            end else if (x < lo) begin
                xc = lo;
            end else begin
                xc = x;
            end
            d  = xc - lo;
            s  = hi - lo;
            n1_zero[l] = (hi <= lo);
            n1_d[l]    = d[VAL_W-1:0];
            n1_span[l] = s[VAL_W-1:0];
        end
    end

    // Stage 2: times (2^bits - 1) as shift and subtract
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            if (l == LANE_POS) begin
                n2_num[l] = {r1_d[l], 16'd0} - {16'd0, r1_d[l]};
            end else begin
                n2_num[l] = {4'd0, r1_d[l], 12'd0} - {16'd0, r1_d[l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_motor <= i_motor;
            r1_d     <= n1_d;
            r1_span  <= n1_span;
            r1_zero  <= n1_zero;
            r2_motor <= r1_motor;
            r2_num   <= n2_num;
            r2_span  <= r1_span;
            r2_zero  <= r1_zero;
        end
    end

    assign o_valid = r2_valid;
    assign o_motor = r2_motor;
    assign o_num   = r2_num;
    assign o_span  = r2_span;
    assign o_zero  = r2_zero;

endmodule

FILE: hdl/mcfe_div.sv
// ----------------------------------------------------------------------------
// mcfe_div
// Pipelined restoring divider, one quotient bit per stage for all lanes,
// followed by a round-to-nearest-even stage with saturation.
// ----------------------------------------------------------------------------
module mcfe_div
    import mcfe_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [7:0]                         i_motor,
    input  logic [NLANE-1:0][NUM_W-1:0]        i_num,
    input  logic [NLANE-1:0][VAL_W-1:0]        i_span,
    input  logic [NLANE-1:0]                   i_zero,
    output logic                               o_valid,
    output logic [7:0]                         o_motor,
    output logic [NLANE-1:0][CODE_W-1:0]       o_code
);

    logic [DIV_STEPS-1:0]                             r_valid;
    logic [DIV_STEPS-1:0][7:0]                        r_motor;
    logic [DIV_STEPS-1:0][NLANE-1:0][VAL_W-1:0]       r_rem;
    logic [DIV_STEPS-1:0][NLANE-1:0][CODE_W-1:0]      r_low;
    logic [DIV_STEPS-1:0][NLANE-1:0][CODE_W-1:0]      r_q;
    logic [DIV_STEPS-1:0][NLANE-1:0][VAL_W-1:0]       r_span;
    logic [DIV_STEPS-1:0][NLANE-1:0]                  r_zero;

    logic                                             r_out_valid;
    logic [7:0]                                       r_out_motor;
    logic [NLANE-1:0][CODE_W-1:0]                     r_code;
    logic [NLANE-1:0][CODE_W-1:0]                     n_code;

    // Division stages
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                            p_valid;
        logic [7:0]                      p_motor;
        logic [NLANE-1:0][VAL_W-1:0]     p_rem;
        logic [NLANE-1:0][CODE_W-1:0]    p_low;
        logic [NLANE-1:0][CODE_W-1:0]    p_q;
        logic [NLANE-1:0][VAL_W-1:0]     p_span;
        logic [NLANE-1:0]                p_zero;
        logic [NLANE-1:0][VAL_W-1:0]     n_rem;
        logic [NLANE-1:0][CODE_W-1:0]    n_q;

        if (k == 0) begin : g_first
            always_comb begin
                p_valid = i_valid;
                p_motor = i_motor;
                p_span  = i_span;
                p_zero  = i_zero;
                for (int l = 0; l < NLANE; l++) begin
                    // numerator < span * 2^16, so the top part is below span
                    p_rem[l] = i_num[l][NUM_W-1:CODE_W];
                    p_low[l] = i_num[l][CODE_W-1:0];
                    p_q[l]   = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                p_valid = r_valid[k-1];
                p_motor = r_motor[k-1];
                p_rem   = r_rem[k-1];
                p_low   = r_low[k-1];
                p_q     = r_q[k-1];
                p_span  = r_span[k-1];
                p_zero  = r_zero[k-1];
            end
        end

        // one trial subtract per lane
        always_comb begin
            logic [VAL_W:0] t;
            logic           ge;
            for (int l = 0; l < NLANE; l++) begin
                t        = {p_rem[l], p_low[l][CODE_W-1]};
                ge       = (t >= {1'b0, p_span[l]});
                n_rem[l] = ge ? VAL_W'(t - {1'b0, p_span[l]}) : t[VAL_W-1:0];
                n_q[l]   = {p_q[l][CODE_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_motor[k] <= p_motor;
                r_rem[k]   <= n_rem;
                for (int l = 0; l < NLANE; l++) begin
                    r_low[k][l] <= {p_low[l][CODE_W-2:0], 1'b0};
                end
                r_q[k]     <= n_q;
                r_span[k]  <= p_span;
                r_zero[k]  <= p_zero;
            end
        end
    end

    // Rounding: half up, exact half to even, saturate, empty range to zero
    always_comb begin
        logic [VAL_W:0]    twor;
        logic              inc;
        logic [CODE_W:0]   qi;
        logic [CODE_W:0]   maxraw;
        for (int l = 0; l < NLANE; l++) begin
            twor   = {r_rem[DIV_STEPS-1][l], 1'b0};
            inc    = (twor > {1'b0, r_span[DIV_STEPS-1][l]}) ||
                     ((twor == {1'b0, r_span[DIV_STEPS-1][l]}) &&
                      r_q[DIV_STEPS-1][l][0]);
            qi     = {1'b0, r_q[DIV_STEPS-1][l]} + {{CODE_W{1'b0}}, inc};
            maxraw = (l == LANE_POS) ? 17'h0FFFF : 17'h00FFF;
            if (r_zero[DIV_STEPS-1][l]) begin
                n_code[l] = '0;
            end else if (qi > maxraw) begin
                n_code[l] = maxraw[CODE_W-1:0];
            end else begin
                n_code[l] = qi[CODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_motor <= r_motor[DIV_STEPS-1];
            r_code      <= n_code;
        end
    end

    assign o_valid = r_out_valid;
    assign o_motor = r_out_motor;
    assign o_code  = r_code;

endmodule

FILE: hdl/mcfe_ser.sv
// ----------------------------------------------------------------------------
// mcfe_ser
// Packs the codes into a frame with checksum and sends it one byte per item.
// ----------------------------------------------------------------------------
module mcfe_ser
    import mcfe_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [7:0]                         i_motor,
    input  logic [NLANE-1:0][CODE_W-1:0]       i_code,
    output logic                               o_take,
    output logic                               o_valid,
    input  logic                               i_ready,
    output t_frame_out                         o_frame
);

    logic [FRAME_LEN-1:0][7:0] r_frame;
    logic [FRAME_LEN-1:0][7:0] n_frame;
    logic [3:0]                r_idx;
    logic                      r_busy;
    logic                      w_last;
    logic                      w_load;

    assign w_last = (r_idx == 4'(FRAME_LEN - 1));
    assign o_take = !r_busy || (i_ready && w_last);
    assign w_load = i_valid && o_take;

    // Frame assembly and checksum
    always_comb begin
        logic [7:0] x;
        logic [CODE_W-1:0] pos, vel, tor, kp, kd;
        pos = i_code[LANE_POS];
        vel = i_code[LANE_VEL];
        tor = i_code[LANE_TOR];
        kp  = i_code[LANE_KP];
        kd  = i_code[LANE_KD];
        n_frame[0] = HEADER_BYTE;
        n_frame[1] = i_motor;
        n_frame[2] = pos[15:8];
        n_frame[3] = pos[7:0];
        n_frame[4] = vel[11:4];
        n_frame[5] = {vel[3:0], kp[11:8]};
        n_frame[6] = kp[7:0];
        n_frame[7] = kd[11:4];
        n_frame[8] = {kd[3:0], tor[11:8]};
        n_frame[9] = tor[7:0];
        x = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            x = x ^ n_frame[i];
        end
        n_frame[FRAME_LEN-1] = x;
    end

    // Byte sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx  <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_frame <= n_frame;
        end else if (r_busy && i_ready) begin
            r_frame <= {8'd0, r_frame[FRAME_LEN-1:1]};
        end
    end

    assign o_valid            = r_busy;
    assign o_frame.frame_byte = r_frame[0];
    assign o_frame.last_byte  = w_last;

endmodule

FILE: hdl/motor_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// Turns one motor command into an 11-byte frame with XOR checksum.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one command item (motor number and
// five Q16.16 setpoints). Output channel o_valid/i_ready carries one frame
// byte per item, o_frame.last_byte marking the checksum byte.
// Range registers are to be written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block is idle, which it does not enforce; there is no read-back.
// Each command runs through a 20-stage pipeline: clamp, scale, 16 stages of
// a restoring divider (one quotient bit per stage), rounding, then frame load.
// The serialiser sends one byte per cycle while the receiver is ready; the
// next frame loads as the last byte leaves.
// When the receiver stalls, the serialiser holds its byte and the whole
// pipeline freezes once its last stage is full; nothing is lost or repeated.
// Reset clears all valid bits and loads the default ranges.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder
    import mcfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_cmd                  i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_frame_out            o_frame
);

    logic [NREG-1:0][31:0]              r_cfg;
    logic [NLANE-1:0][VAL_W-1:0]        w_x, w_lo, w_hi;
    logic                               w_en;
    logic                               prep_valid;
    logic [7:0]                         prep_motor;
    logic [NLANE-1:0][NUM_W-1:0]        prep_num;
    logic [NLANE-1:0][VAL_W-1:0]        prep_span;
    logic [NLANE-1:0]                   prep_zero;
    logic                               div_valid;
    logic [7:0]                         div_motor;
    logic [NLANE-1:0][CODE_W-1:0]       div_code;
    logic                               ser_take;

    // Range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_POS_MIN]   <= RST_POS_MIN;
            r_cfg[REG_POS_MAX]   <= RST_POS_MAX;
            r_cfg[REG_VEL_MIN]   <= RST_VEL_MIN;
            r_cfg[REG_VEL_MAX]   <= RST_VEL_MAX;
            r_cfg[REG_TOR_MIN]   <= RST_TOR_MIN;
            r_cfg[REG_TOR_MAX]   <= RST_TOR_MAX;
            r_cfg[REG_STIFF_MAX] <= RST_STIFF_MAX;
            r_cfg[REG_DAMP_MAX]  <= RST_DAMP_MAX;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STIFF_MAX || i_cfg_idx == REG_DAMP_MAX) begin
                r_cfg[i_cfg_idx] <= {1'b0, i_cfg_data[30:0]};
            end else begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // Lane routing; gains have a lower bound of zero
    assign w_x[LANE_POS]  = i_cmd.target_position;
    assign w_x[LANE_VEL]  = i_cmd.target_velocity;
    assign w_x[LANE_TOR]  = i_cmd.target_torque;
    assign w_x[LANE_KP]   = i_cmd.stiffness_gain;
    assign w_x[LANE_KD]   = i_cmd.damping_gain;
    assign w_lo[LANE_POS] = r_cfg[REG_POS_MIN];
    assign w_hi[LANE_POS] = r_cfg[REG_POS_MAX];
    assign w_lo[LANE_VEL] = r_cfg[REG_VEL_MIN];
    assign w_hi[LANE_VEL] = r_cfg[REG_VEL_MAX];
    assign w_lo[LANE_TOR] = r_cfg[REG_TOR_MIN];
    assign w_hi[LANE_TOR] = r_cfg[REG_TOR_MAX];
    assign w_lo[LANE_KP]  = '0;
    assign w_hi[LANE_KP]  = r_cfg[REG_STIFF_MAX];
    assign w_lo[LANE_KD]  = '0;
    assign w_hi[LANE_KD]  = r_cfg[REG_DAMP_MAX];

    // Pipeline advances unless a finished item waits on the serialiser
    assign w_en    = !div_valid || ser_take;
    assign o_ready = w_en;

    mcfe_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_motor (i_cmd.motor_number),
        .i_x     (w_x),
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .o_valid (prep_valid),
        .o_motor (prep_motor),
        .o_num   (prep_num),
        .o_span  (prep_span),
        .o_zero  (prep_zero)
    );

    mcfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (prep_valid),
        .i_motor (prep_motor),
        .i_num   (prep_num),
        .i_span  (prep_span),
        .i_zero  (prep_zero),
        .o_valid (div_valid),
        .o_motor (div_motor),
        .o_code  (div_code)
    );

    mcfe_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_motor (div_motor),
        .i_code  (div_code),
        .o_take  (ser_take),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_frame (o_frame)
    );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Frame encoder test: commands with random handshakes, frames checked per byte.
// Each accepted command is quantised by a local predictor; the expected frame
// bytes queue up and every byte leaving the block is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mcfe_pkg::*;

class frame_scoreboard;
    logic [31:0] range_reg [NREG];
    t_frame_out  frame_q [$];
    int          mismatches;
    int          bytes_checked;

    function new();
        range_reg[REG_POS_MIN]   = RST_POS_MIN;
        range_reg[REG_POS_MAX]   = RST_POS_MAX;
        range_reg[REG_VEL_MIN]   = RST_VEL_MIN;
        range_reg[REG_VEL_MAX]   = RST_VEL_MAX;
        range_reg[REG_TOR_MIN]   = RST_TOR_MIN;
        range_reg[REG_TOR_MAX]   = RST_TOR_MAX;
        range_reg[REG_STIFF_MAX] = RST_STIFF_MAX;
        range_reg[REG_DAMP_MAX]  = RST_DAMP_MAX;
        mismatches = 0;
        bytes_checked = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
        if (idx == REG_STIFF_MAX || idx == REG_DAMP_MAX)
            range_reg[idx] = {1'b0, data[30:0]};
        else
            range_reg[idx] = data;
    endfunction

    // Clamp, scale and round to nearest (ties to even)
    function logic [15:0] to_code(longint x, longint lo, longint hi, int bits);
        longint span, num, q, r, top;
        if (hi <= lo)
            return 16'd0;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        span = hi - lo;
        top  = (64'sd1 <<< bits) - 1;
        num  = (x - lo) * top;
        q    = num / span;
        r    = num % span;
        if (2 * r > span || (2 * r == span && q[0]))
            q++;
        if (q > top) q = top;
        return q[15:0];
    endfunction

    function void note_command(t_cmd c);
        logic [15:0] pos, vel, tor, kp, kd;
        logic [7:0]  b [FRAME_LEN];
        logic [7:0]  chk;
        t_frame_out  o;
        pos = to_code(longint'(c.target_position), longint'($signed(range_reg[REG_POS_MIN])),
                      longint'($signed(range_reg[REG_POS_MAX])), 16);
        vel = to_code(longint'(c.target_velocity), longint'($signed(range_reg[REG_VEL_MIN])),
                      longint'($signed(range_reg[REG_VEL_MAX])), 12);
        tor = to_code(longint'(c.target_torque), longint'($signed(range_reg[REG_TOR_MIN])),
                      longint'($signed(range_reg[REG_TOR_MAX])), 12);
        kp  = to_code(longint'(c.stiffness_gain), 0,
                      longint'({1'b0, range_reg[REG_STIFF_MAX]}), 12);
        kd  = to_code(longint'(c.damping_gain), 0,
                      longint'({1'b0, range_reg[REG_DAMP_MAX]}), 12);
        b[0] = HEADER_BYTE;
        b[1] = c.motor_number;
        b[2] = pos[15:8];
        b[3] = pos[7:0];
        b[4] = vel[11:4];
        b[5] = {vel[3:0], kp[11:8]};
        b[6] = kp[7:0];
        b[7] = kd[11:4];
        b[8] = {kd[3:0], tor[11:8]};
        b[9] = tor[7:0];
        chk = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            chk ^= b[i];
        b[10] = chk;
        for (int i = 0; i < FRAME_LEN; i++) begin
            o.frame_byte = b[i];
            o.last_byte  = (i == FRAME_LEN - 1);
            frame_q.insert(frame_q.size(), o);
        end
    endfunction

    function void check_byte(t_frame_out got);
        t_frame_out want;
        bytes_checked++;
        if (frame_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected byte %h last %0b", $time, got.frame_byte,
                         got.last_byte);
            return;
        end
        want = frame_q.pop_front();
        if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: byte mismatch: expected %h last %0b, got %h last %0b",
                         $time, want.frame_byte, want.last_byte, got.frame_byte,
                         got.last_byte);
        end
    endfunction
endclass

module tb_top;
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    t_cmd                 i_cmd;
    logic                 o_valid;
    logic                 i_ready;
    t_frame_out           o_frame;

    frame_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cmds_sent;

    motor_command_frame_encoder uut (.*);

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Receiver: random stalls, sampled at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_byte(o_frame);
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Drive one command; valid stays high until accepted and drops only on idle
    task automatic send_cmd(t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_command(c);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.frame_q.size() != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Mix of edge values, values inside the window and full random words
    function automatic logic [31:0] rand_setpoint(logic [31:0] lo, logic [31:0] hi);
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return lo;
            1: return hi;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4, 5: return $urandom;
            default: return lo + ($urandom % ((hi - lo) | 32'd1));
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.motor_number    = $urandom;
        c.target_position = rand_setpoint(sb.range_reg[REG_POS_MIN], sb.range_reg[REG_POS_MAX]);
        c.target_velocity = rand_setpoint(sb.range_reg[REG_VEL_MIN], sb.range_reg[REG_VEL_MAX]);
        c.target_torque   = rand_setpoint(sb.range_reg[REG_TOR_MIN], sb.range_reg[REG_TOR_MAX]);
        c.stiffness_gain  = rand_setpoint(32'd0, sb.range_reg[REG_STIFF_MAX]);
        c.damping_gain    = rand_setpoint(32'd0, sb.range_reg[REG_DAMP_MAX]);
        return c;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_cmd(rand_cmd());
        wait_drained();
    endtask

    initial begin
        t_cmd c;
        sb = new();
        send_idle_pct = 12;
        recv_idle_pct = 62;
        cmds_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_POS_MIN;
        i_cfg_data = 32'd0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes at the default ranges
        c = '0;
        send_cmd(c);
        c = '1;
        send_cmd(c);
        c = {8'hFF, {5{32'h7FFF_FFFF}}};
        send_cmd(c);
        c = {8'h00, {5{32'h8000_0000}}};
        send_cmd(c);
        // Exactly at bounds
        c = {8'h5A, RST_POS_MIN, RST_VEL_MIN, RST_TOR_MIN, 32'd0, 32'd0};
        send_cmd(c);
        c = {8'hA5, RST_POS_MAX, RST_VEL_MAX, RST_TOR_MAX, RST_STIFF_MAX, RST_DAMP_MAX};
        send_cmd(c);
        wait_drained();

        // Small spans expose rounding ties: span 2, midpoint gives a half tie
        write_reg(REG_POS_MIN, 32'd0);
        write_reg(REG_POS_MAX, 32'd2);
        write_reg(REG_VEL_MIN, 32'hFFFF_FFFF);
        write_reg(REG_VEL_MAX, 32'd1);
        write_reg(REG_TOR_MIN, 32'd10);
        write_reg(REG_TOR_MAX, 32'd10);           // empty range
        write_reg(REG_STIFF_MAX, 32'd2);
        write_reg(REG_DAMP_MAX, 32'd0);           // empty range
        for (int i = 0; i < 4; i++) begin
            c = {8'(i), 32'(i), 32'(i - 1), 32'(i + 9), 32'(i), 32'(i)};
            send_cmd(c);
        end
        wait_drained();

        // Widest ranges and inverted ones
        write_reg(REG_POS_MIN, 32'h8000_0000);
        write_reg(REG_POS_MAX, 32'h7FFF_FFFF);
        write_reg(REG_VEL_MIN, 32'h7FFF_FFFF);
        write_reg(REG_VEL_MAX, 32'h8000_0000);    // inverted
        write_reg(REG_TOR_MIN, 32'h8000_0000);
        write_reg(REG_TOR_MAX, 32'h7FFF_FFFF);
        write_reg(REG_STIFF_MAX, 32'hFFFF_FFFF);  // top bit dropped
        write_reg(REG_DAMP_MAX, 32'h7FFF_FFFF);
        c = {8'h11, {5{32'h8000_0000}}};
        send_cmd(c);
        c = {8'h22, {5{32'h7FFF_FFFF}}};
        send_cmd(c);
        c = {8'h33, {5{32'h0000_0000}}};
        send_cmd(c);
        random_phase(60);

        // Back to defaults, receiver hardly stalls, sender idles often
        send_idle_pct = 62;
        recv_idle_pct = 12;
        write_reg(REG_POS_MIN, RST_POS_MIN);
        write_reg(REG_POS_MAX, RST_POS_MAX);
        write_reg(REG_VEL_MIN, RST_VEL_MIN);
        write_reg(REG_VEL_MAX, RST_VEL_MAX);
        write_reg(REG_TOR_MIN, RST_TOR_MIN);
        write_reg(REG_TOR_MAX, RST_TOR_MAX);
        write_reg(REG_STIFF_MAX, RST_STIFF_MAX);
        write_reg(REG_DAMP_MAX, RST_DAMP_MAX);
        random_phase(80);

        // Random ranges, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int r = 0; r < NREG; r++)
            write_reg(REG_IDX_W'(r), (r >= REG_STIFF_MAX) ? ($urandom >> 4)
                                                           : ($urandom >>> 2));
        random_phase(80);

        $display("Sent %0d commands over five range settings; %0d frame bytes checked.",
                 cmds_sent, sb.bytes_checked);
        if (sb.mismatches == 0 && sb.frame_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
